// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BSPSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every rising clock edge, reset included.
`define BSPSE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/bspse_pkg.sv -----
`timescale 1ns / 1ps

package bspse_pkg;

    localparam int MAX_ORDER_DEF = 4;
    localparam int GRID_MAX_DEF  = 64;

    localparam int DATA_W    = 32;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DEN_W     = 33;
    localparam int QUO_W     = 33;
    localparam int FRAC      = 30;
    localparam int DIV_QBITS = 31;
    localparam int ADDR_W    = 4;

    // Q2.30 one and the symmetric clip limit 2^31
    localparam logic signed [MUL_W-1:0] BASIS_ONE = 33'sh0_4000_0000;
    localparam logic signed [MUL_W-1:0] Q_LIM     = 33'sh0_8000_0000;

    localparam logic [1:0] CMD_WR_UKNOT = 2'd0;
    localparam logic [1:0] CMD_WR_VKNOT = 2'd1;
    localparam logic [1:0] CMD_WR_CTRL  = 2'd2;
    localparam logic [1:0] CMD_EVAL     = 2'd3;

    localparam logic [1:0] REG_U_ORDER = 2'd0;
    localparam logic [1:0] REG_V_ORDER = 2'd1;
    localparam logic [1:0] REG_U_COUNT = 2'd2;
    localparam logic [1:0] REG_V_COUNT = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [6:0]               knot_index;
        logic signed [DATA_W-1:0] knot_value;
        logic [5:0]               grid_u;
        logic [5:0]               grid_v;
        logic signed [DATA_W-1:0] ctrl_x;
        logic signed [DATA_W-1:0] ctrl_y;
        logic signed [DATA_W-1:0] ctrl_z;
        logic signed [DATA_W-1:0] param_u;
        logic signed [DATA_W-1:0] param_v;
    } t_in_item;

    typedef struct packed {
        logic                     in_range;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
    } t_out_item;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] num;
        logic signed [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quo;
    } t_div_rsp;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
        if (v > 33'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -33'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [MUL_W-1:0] clip31(input logic signed [PROD_W-1:0] v);
        if (v > PROD_W'(Q_LIM)) begin
            return Q_LIM;
        end else if (v < -PROD_W'(Q_LIM)) begin
            return -Q_LIM;
        end
        return v[MUL_W-1:0];
    endfunction

endpackage

// ----- hdl/bspse_ram.sv -----
`timescale 1ns / 1ps

module bspse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/bspse_div.sv -----
`timescale 1ns / 1ps

module bspse_div
    import bspse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int HI_W  = PROD_W - DIV_QBITS;
    localparam int CNT_W = $clog2(DIV_QBITS + 1);

    logic [PROD_W-1:0]    nmag;
    logic [DEN_W-1:0]     dmag;
    logic [HI_W-1:0]      nhi;
    logic                 ovf;
    logic [DEN_W:0]       trial;
    logic                 ge;
    logic [DEN_W:0]       diff;
    logic [DIV_QBITS-1:0] qn;
    logic [QUO_W-1:0]     qmag;

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic signed [QUO_W-1:0] r_quo;
    logic [DEN_W-1:0]      r_rem;
    logic [DEN_W-1:0]      r_dmag;
    logic [DIV_QBITS-1:0]  r_nlo;
    logic [DIV_QBITS-1:0]  r_q;
    logic                  r_neg;

    always_comb begin
        nmag  = i_req.num[PROD_W-1] ? PROD_W'(-i_req.num) : PROD_W'(i_req.num);
        dmag  = i_req.den[DEN_W-1] ? DEN_W'(-i_req.den) : DEN_W'(i_req.den);
        nhi   = nmag[PROD_W-1:DIV_QBITS];
        ovf   = nhi >= HI_W'(dmag);
        trial = {r_rem, r_nlo[DIV_QBITS-1]};
        ge    = trial >= (DEN_W+1)'(r_dmag);
        diff  = trial - (DEN_W+1)'(r_dmag);
        qn    = {r_q[DIV_QBITS-2:0], ge};
        qmag  = QUO_W'(qn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg  <= i_req.num[PROD_W-1] ^ i_req.den[DEN_W-1];
                r_dmag <= dmag;
                r_rem  <= DEN_W'(nhi);
                r_nlo  <= nmag[DIV_QBITS-1:0];
                r_q    <= '0;
                if (dmag == '0) begin
                    // zero denominator: the term is zero
                    r_quo  <= '0;
                    r_done <= 1'b1;
                end else if (ovf) begin
                    r_quo  <= (i_req.num[PROD_W-1] ^ i_req.den[DEN_W-1]) ? -Q_LIM : Q_LIM;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(DIV_QBITS);
                end
            end else if (r_busy) begin
                r_rem <= ge ? DEN_W'(diff) : DEN_W'(trial);
                r_nlo <= {r_nlo[DIV_QBITS-2:0], 1'b0};
                r_q   <= qn;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quo  <= r_neg ? -$signed(qmag) : $signed(qmag);
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- hdl/bspline_surface_point_eval_core.sv -----
`timescale 1ns / 1ps

// B-spline surface point evaluator. Write commands (u knot, v knot, control
// point) complete in the cycle they are transferred and never raise busy or
// produce a result. An evaluate command with a good configuration raises
// busy until its single result is shown on o_result for exactly one cycle
// with o_valid; the receiver cannot stall it, so take it when it appears.
// Evaluation runs on one shared 33x33 multiplier and one radix-2 divider
// (31 steps per quotient) under a small sequencer: a range check per
// direction, a binary search for each span, Cox-de Boor terms of two
// divisions each (deg*(deg+1)/2 terms per direction, so 6 terms at order 4)
// and a multiply-accumulate per control point of the u_order x v_order patch.
// A parameter out of the knot range answers before the span search; an
// evaluate with a bad configuration gets a miss without raising busy.
// Configuration registers (APB, byte offsets 0/4/8/12: u_order, v_order,
// u_count, v_count) are to be written only while the block is idle.
module bspline_surface_point_eval_core
    import bspse_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int GRID_MAX  = GRID_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_valid,
    output t_out_item         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int KNOT_DEPTH = GRID_MAX + MAX_ORDER;
    localparam int KI_W       = $clog2(KNOT_DEPTH);
    localparam int IW         = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CP_DEPTH   = GRID_MAX * GRID_MAX;
    localparam int CP_AW      = $clog2(CP_DEPTH);
    localparam int SH_W       = PROD_W - FRAC;
    localparam int ACC_W      = SH_W + 2 * IW + 1;

    typedef enum logic [24:0] {
        S_IDLE  = 25'h0000001,
        S_RLO   = 25'h0000002,
        S_RHI   = 25'h0000004,
        S_RCHK  = 25'h0000008,
        S_SP0   = 25'h0000010,
        S_SP1   = 25'h0000020,
        S_SRCH  = 25'h0000040,
        S_SCMP  = 25'h0000080,
        S_BINIT = 25'h0000100,
        S_BL    = 25'h0000200,
        S_BR    = 25'h0000400,
        S_BS    = 25'h0000800,
        S_M1    = 25'h0001000,
        S_D1    = 25'h0002000,
        S_W1    = 25'h0004000,
        S_M2    = 25'h0008000,
        S_D2    = 25'h0010000,
        S_W2    = 25'h0020000,
        S_SINIT = 25'h0040000,
        S_W0    = 25'h0080000,
        S_WC    = 25'h0100000,
        S_PX    = 25'h0200000,
        S_PY    = 25'h0400000,
        S_PZ    = 25'h0800000,
        S_PE    = 25'h1000000
    } t_state;

    // configuration registers
    logic [2:0] r_u_order;
    logic [2:0] r_v_order;
    logic [6:0] r_u_count;
    logic [6:0] r_v_count;

    // sequencer and datapath registers
    t_state                    r_state;
    t_state                    n_state;
    logic                      r_dir;
    logic signed [DATA_W-1:0]  r_pu;
    logic signed [DATA_W-1:0]  r_pv;
    logic [KI_W-1:0]           r_lo;
    logic [KI_W-1:0]           r_hi;
    logic [KI_W-1:0]           r_span [2];
    logic [IW-1:0]             r_j;
    logic [IW-1:0]             r_r;
    logic signed [DATA_W-1:0]  r_lft [MAX_ORDER];
    logic signed [DATA_W-1:0]  r_rgt [MAX_ORDER];
    logic signed [MUL_W-1:0]   r_nb [2][MAX_ORDER];
    logic signed [MUL_W-1:0]   r_carry;
    logic signed [QUO_W-1:0]   r_qa;
    logic signed [DEN_W-1:0]   r_den;
    logic [IW-1:0]             r_a;
    logic [IW-1:0]             r_b;
    logic signed [MUL_W-1:0]   r_w;
    logic signed [ACC_W-1:0]   r_acc_x;
    logic signed [ACC_W-1:0]   r_acc_y;
    logic signed [ACC_W-1:0]   r_acc_z;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_valid;
    t_out_item                 r_res;

    // combinational
    logic                      accept;
    logic                      cfg_wr;
    logic                      cfg_good;
    logic [KI_W-1:0]           du;
    logic [KI_W-1:0]           dv;
    logic [KI_W-1:0]           cur_deg;
    logic [KI_W-1:0]           cur_cnt;
    logic [KI_W-1:0]           cur_span;
    logic signed [DATA_W-1:0]  cur_t;
    logic signed [DATA_W-1:0]  kq;
    logic [DATA_W-1:0]         uk_q;
    logic [DATA_W-1:0]         vk_q;
    logic [3*DATA_W-1:0]       cp_q;
    logic [KI_W-1:0]           k_raddr;
    logic [KI_W-1:0]           k_waddr;
    logic                      k_wr_ok;
    logic                      uk_we;
    logic                      vk_we;
    logic                      cp_we;
    logic [CP_AW-1:0]          cp_waddr;
    logic [CP_AW-1:0]          cp_raddr;
    logic [KI_W-1:0]           cu;
    logic [KI_W-1:0]           cv;
    logic [KI_W:0]             mid_sum;
    logic [KI_W-1:0]           mid;
    logic                      search_on;
    logic                      last_r;
    logic                      last_j;
    logic                      last_a;
    logic                      last_b;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SH_W-1:0]    prod_sh;
    logic signed [ACC_W-1:0]   acc_z_nx;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    function automatic logic cfg_ok(input logic [2:0] ord, input logic [6:0] cnt);
        return (ord != 3'd0) && (32'(ord) <= MAX_ORDER) && (cnt >= {4'b0, ord})
            && (32'(cnt) <= GRID_MAX);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (v < ACC_W'(32'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Configuration port: no wait states, writes land on the access phase.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_order <= 3'd4;
            r_v_order <= 3'd4;
            r_u_count <= 7'd4;
            r_v_count <= 7'd4;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_U_ORDER: r_u_order <= pwdata[2:0];
                REG_V_ORDER: r_v_order <= pwdata[2:0];
                REG_U_COUNT: r_u_count <= pwdata[6:0];
                REG_V_COUNT: r_v_count <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_U_ORDER: prdata = {29'b0, r_u_order};
            REG_V_ORDER: prdata = {29'b0, r_v_order};
            REG_U_COUNT: prdata = {25'b0, r_u_count};
            REG_V_COUNT: prdata = {25'b0, r_v_count};
        endcase
    end

    // ---------------------------------------------------------------------
    // Command transfer. Writes go straight into the stores; an evaluate
    // with a bad configuration answers right away with a miss.
    // ---------------------------------------------------------------------
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign cfg_good = cfg_ok(r_u_order, r_u_count) && cfg_ok(r_v_order, r_v_count);

    assign k_waddr  = KI_W'(i_item.knot_index);
    assign k_wr_ok  = accept && (32'(i_item.knot_index) < KNOT_DEPTH);
    assign uk_we    = k_wr_ok && (i_item.cmd == CMD_WR_UKNOT);
    assign vk_we    = k_wr_ok && (i_item.cmd == CMD_WR_VKNOT);
    assign cp_we    = accept && (i_item.cmd == CMD_WR_CTRL)
                      && (32'(i_item.grid_u) < GRID_MAX) && (32'(i_item.grid_v) < GRID_MAX);
    assign cp_waddr = CP_AW'(32'(i_item.grid_v) * GRID_MAX + 32'(i_item.grid_u));

    // ---------------------------------------------------------------------
    // Per-direction view: r_dir picks u (0) or v (1) for the range check,
    // span search and basis recursion, which share the same states.
    // ---------------------------------------------------------------------
    assign du       = KI_W'(r_u_order) - KI_W'(1);
    assign dv       = KI_W'(r_v_order) - KI_W'(1);
    assign cur_deg  = r_dir ? dv : du;
    assign cur_cnt  = r_dir ? KI_W'(r_v_count) : KI_W'(r_u_count);
    assign cur_t    = r_dir ? r_pv : r_pu;
    assign kq       = r_dir ? $signed(vk_q) : $signed(uk_q);
    assign cur_span = r_span[r_dir];

    assign mid_sum   = (KI_W+1)'(r_lo) + (KI_W+1)'(r_hi);
    assign mid       = mid_sum[KI_W:1];
    assign search_on = (r_hi - r_lo) > KI_W'(1);
    assign last_r    = (r_r == r_j - IW'(1));
    assign last_j    = (KI_W'(r_j) == cur_deg);
    assign last_a    = (KI_W'(r_a) == du);
    assign last_b    = (KI_W'(r_b) == dv);

    // knot read address; data shows up in kq in the following cycle
    always_comb begin
        priority case (1'b1)
            r_state == S_RLO:  k_raddr = cur_deg;
            r_state == S_RHI:  k_raddr = cur_cnt;
            r_state == S_SP0:  k_raddr = cur_cnt;
            r_state == S_SRCH: k_raddr = mid;
            r_state == S_BL:   k_raddr = cur_span + KI_W'(1) - KI_W'(r_j);
            r_state == S_BR:   k_raddr = cur_span + KI_W'(r_j);
            default:           k_raddr = '0;
        endcase
    end

    // control point patch address follows the patch counters
    assign cu       = r_span[0] - du + KI_W'(r_a);
    assign cv       = r_span[1] - dv + KI_W'(r_b);
    assign cp_raddr = CP_AW'(32'(cv) * GRID_MAX + 32'(cu));

    bspse_ram #(.WIDTH(DATA_W), .DEPTH(KNOT_DEPTH)) u_uknot (
        .i_clk   (i_clk),
        .i_we    (uk_we),
        .i_waddr (k_waddr),
        .i_wdata (i_item.knot_value),
        .i_raddr (k_raddr),
        .o_rdata (uk_q)
    );

    bspse_ram #(.WIDTH(DATA_W), .DEPTH(KNOT_DEPTH)) u_vknot (
        .i_clk   (i_clk),
        .i_we    (vk_we),
        .i_waddr (k_waddr),
        .i_wdata (i_item.knot_value),
        .i_raddr (k_raddr),
        .o_rdata (vk_q)
    );

    bspse_ram #(.WIDTH(3 * DATA_W), .DEPTH(CP_DEPTH)) u_ctrl (
        .i_clk   (i_clk),
        .i_we    (cp_we),
        .i_waddr (cp_waddr),
        .i_wdata ({i_item.ctrl_x, i_item.ctrl_y, i_item.ctrl_z}),
        .i_raddr (cp_raddr),
        .o_rdata (cp_q)
    );

    // ---------------------------------------------------------------------
    // Shared multiplier, registered every cycle. Operands follow the state.
    // ---------------------------------------------------------------------
    always_comb begin
        priority case (1'b1)
            r_state == S_M1: begin
                mul_a = MUL_W'(r_rgt[r_r + IW'(1)]);
                mul_b = r_nb[r_dir][r_r];
            end
            r_state == S_M2: begin
                mul_a = MUL_W'(r_lft[r_j - r_r]);
                mul_b = r_nb[r_dir][r_r];
            end
            r_state == S_W0: begin
                mul_a = r_nb[1][r_b];
                mul_b = r_nb[0][r_a];
            end
            r_state == S_PX: begin
                mul_a = r_w;
                mul_b = MUL_W'($signed(cp_q[3*DATA_W-1:2*DATA_W]));
            end
            r_state == S_PY: begin
                mul_a = r_w;
                mul_b = MUL_W'($signed(cp_q[2*DATA_W-1:DATA_W]));
            end
            r_state == S_PZ: begin
                mul_a = r_w;
                mul_b = MUL_W'($signed(cp_q[DATA_W-1:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
    // product in Q16.16 (or Q2.30 for the weight), rounded toward minus infinity
    assign prod_sh  = r_prod[PROD_W-1:FRAC];
    assign acc_z_nx = r_acc_z + ACC_W'(prod_sh);

    // ---------------------------------------------------------------------
    // Shared divider: one basis term numerator over its knot-span sum.
    // ---------------------------------------------------------------------
    assign div_req.start = (r_state == S_D1) || (r_state == S_D2);
    assign div_req.num   = r_prod;
    assign div_req.den   = r_den;

    bspse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.cmd == CMD_EVAL) && cfg_good) begin
                    n_state = S_RLO;
                end
            end
            S_RLO:  n_state = S_RHI;
            S_RHI:  n_state = (cur_t < kq) ? S_IDLE : S_RCHK;
            S_RCHK: begin
                if (cur_t > kq) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = r_dir ? S_SP0 : S_RLO;
                end
            end
            S_SP0:  n_state = S_SP1;
            S_SP1:  n_state = (cur_t >= kq) ? S_BINIT : S_SRCH;
            S_SRCH: n_state = search_on ? S_SCMP : S_BINIT;
            S_SCMP: n_state = S_SRCH;
            S_BINIT: begin
                if (cur_deg == '0) begin
                    n_state = r_dir ? S_SINIT : S_SP0;
                end else begin
                    n_state = S_BL;
                end
            end
            S_BL:   n_state = S_BR;
            S_BR:   n_state = S_BS;
            S_BS:   n_state = S_M1;
            S_M1:   n_state = S_D1;
            S_D1:   n_state = S_W1;
            S_W1:   n_state = div_rsp.done ? S_M2 : S_W1;
            S_M2:   n_state = S_D2;
            S_D2:   n_state = S_W2;
            S_W2: begin
                if (div_rsp.done) begin
                    if (!last_r) begin
                        n_state = S_M1;
                    end else if (!last_j) begin
                        n_state = S_BL;
                    end else begin
                        n_state = r_dir ? S_SINIT : S_SP0;
                    end
                end
            end
            S_SINIT: n_state = S_W0;
            S_W0:    n_state = S_WC;
            S_WC:    n_state = S_PX;
            S_PX:    n_state = S_PY;
            S_PY:    n_state = S_PZ;
            S_PZ:    n_state = S_PE;
            S_PE:    n_state = (last_a && last_b) ? S_IDLE : S_W0;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            // drop a miss result when a range check fails or the setup is bad
            if (((r_state == S_IDLE) && accept && (i_item.cmd == CMD_EVAL) && !cfg_good)
                || ((r_state == S_RHI) && (cur_t < kq))
                || ((r_state == S_RCHK) && (cur_t > kq))) begin
                r_valid <= 1'b1;
            end
            if ((r_state == S_PE) && last_a && last_b) begin
                r_valid <= 1'b1;
            end
        end
    end

    // datapath: payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            S_IDLE: begin
                r_pu  <= i_item.param_u;
                r_pv  <= i_item.param_v;
                r_dir <= 1'b0;
                r_res <= '0;
            end
            S_RHI: begin
                r_res <= '0;
            end
            S_RCHK: begin
                r_res <= '0;
                if (!(cur_t > kq)) begin
                    r_dir <= ~r_dir;
                end
            end
            S_SP1: begin
                // the top knot itself clamps into the last span
                r_span[r_dir] <= cur_cnt - KI_W'(1);
                r_lo          <= cur_deg;
                r_hi          <= cur_cnt;
            end
            S_SRCH: begin
                r_span[r_dir] <= r_lo;
            end
            S_SCMP: begin
                if (cur_t < kq) begin
                    r_hi <= mid;
                end else begin
                    r_lo <= mid;
                end
            end
            S_BINIT: begin
                r_nb[r_dir][0] <= BASIS_ONE;
                r_j            <= IW'(1);
                if ((cur_deg == '0) && !r_dir) begin
                    r_dir <= 1'b1;
                end
            end
            S_BR: begin
                r_lft[r_j] <= sat32({cur_t[DATA_W-1], cur_t} - {kq[DATA_W-1], kq});
            end
            S_BS: begin
                r_rgt[r_j] <= sat32({kq[DATA_W-1], kq} - {cur_t[DATA_W-1], cur_t});
                r_r        <= '0;
                r_carry    <= '0;
            end
            S_M1: begin
                r_den <= DEN_W'(r_rgt[r_r + IW'(1)]) + DEN_W'(r_lft[r_j - r_r]);
            end
            S_W1: begin
                r_qa <= div_rsp.quo;
            end
            S_W2: begin
                if (div_rsp.done) begin
                    r_nb[r_dir][r_r] <= clip31(PROD_W'(r_carry) + PROD_W'(r_qa));
                    r_carry          <= div_rsp.quo;
                    if (last_r) begin
                        r_nb[r_dir][r_j] <= div_rsp.quo;
                        if (last_j) begin
                            r_dir <= 1'b1;
                        end else begin
                            r_j <= r_j + IW'(1);
                        end
                    end else begin
                        r_r <= r_r + IW'(1);
                    end
                end
            end
            S_SINIT: begin
                r_a     <= '0;
                r_b     <= '0;
                r_acc_x <= '0;
                r_acc_y <= '0;
                r_acc_z <= '0;
            end
            S_WC: begin
                r_w <= clip31(PROD_W'(prod_sh));
            end
            S_PY: begin
                r_acc_x <= r_acc_x + ACC_W'(prod_sh);
            end
            S_PZ: begin
                r_acc_y <= r_acc_y + ACC_W'(prod_sh);
            end
            S_PE: begin
                r_acc_z <= acc_z_nx;
                if (last_a) begin
                    r_a <= '0;
                    r_b <= r_b + IW'(1);
                end else begin
                    r_a <= r_a + IW'(1);
                end
                r_res.in_range <= 1'b1;
                r_res.out_x    <= sat_acc(r_acc_x);
                r_res.out_y    <= sat_acc(r_acc_y);
                r_res.out_z    <= sat_acc(acc_z_nx);
            end
            S_RLO, S_SP0, S_BL, S_D1, S_M2, S_D2, S_W0, S_PX: begin
            end
            default: begin
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ----- hdl/bspse_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bspse_chk
    import bspse_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input t_in_item          i_item,
    input logic              o_valid,
    input t_out_item         o_result,
    input logic              pready
);

    `BSPSE_ASSERT(a_miss_zero, (o_valid && !o_result.in_range) |-> (o_result.out_x == 0 && o_result.out_y == 0 && o_result.out_z == 0), "miss result carries nonzero coordinates")
    `BSPSE_ASSERT(a_write_no_busy, (start && !busy && i_item.cmd != CMD_EVAL) |=> !busy, "write command raised busy")
    `BSPSE_ASSERT(a_eval_reacts, (start && !busy && i_item.cmd == CMD_EVAL) |=> (busy || o_valid), "evaluate neither started nor answered")
    `BSPSE_ASSERT(a_result_idle, o_valid |-> !busy, "result shown while still busy")
    `BSPSE_ASSERT_ALWAYS(a_no_wait, pready, "configuration port inserted a wait state")

endmodule

bind bspline_surface_point_eval_core bspse_chk u_bspse_chk (.*);
